// ----- hw/rtl/conv3x3_pixel_filter_assert.svh -----
// assertion macros for the 3x3 pixel filter
`ifndef CONV3X3_PIXEL_FILTER_ASSERT_SVH
`define CONV3X3_PIXEL_FILTER_ASSERT_SVH

// same-cycle implication
`define C3PF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define C3PF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/c3pf_pkg.sv -----
package c3pf_pkg;

    localparam int PIX_W        = 8;
    localparam int COEF_W       = 16;
    localparam int VAL_W        = 16;
    localparam int X_W          = 10;
    localparam int Y_W          = 12;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 12;
    localparam int KROW_W       = 48;
    localparam int KSIZE        = 3;
    localparam int TAPS         = KSIZE * KSIZE;
    localparam int PROD_W       = PIX_W + 1 + COEF_W;
    localparam int SUM_W        = PROD_W + 4;

    localparam int DEF_MAX_WIDTH = 1024;

    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_KERNEL_TOP   = 3'd2;
    localparam logic [2:0] REG_KERNEL_MID   = 3'd3;
    localparam logic [2:0] REG_KERNEL_BOT   = 3'd4;

    localparam logic [WIDTH_REG_W-1:0]  RST_IMAGE_WIDTH  = 11'd64;
    localparam logic [HEIGHT_REG_W-1:0] RST_IMAGE_HEIGHT = 12'd64;
    localparam logic [KROW_W-1:0]       RST_KERNEL_TOP   = 48'h0000_FF00_0000;
    localparam logic [KROW_W-1:0]       RST_KERNEL_MID   = 48'hFF00_0400_FF00;
    localparam logic [KROW_W-1:0]       RST_KERNEL_BOT   = 48'h0000_FF00_0000;

    localparam logic [VAL_W-1:0] VAL_MAX = 16'hFF00;

    typedef struct packed {
        logic [WIDTH_REG_W-1:0]         width_m1;
        logic [HEIGHT_REG_W-1:0]        height_m1;
        logic [TAPS-1:0][COEF_W-1:0]    coef;
    } cfg_t;

    typedef struct packed {
        logic [X_W-1:0] out_x;
        logic [Y_W-1:0] out_y;
        logic           frame_last;
    } tag_t;

endpackage

// ----- hw/rtl/c3pf_if.sv -----
interface c3pf_pix_if;
    logic                        valid;
    logic                        ready;
    logic [c3pf_pkg::PIX_W-1:0]  pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface c3pf_res_if;
    logic                        valid;
    logic                        ready;
    logic [c3pf_pkg::VAL_W-1:0]  filtered_value;
    logic [c3pf_pkg::X_W-1:0]    out_x;
    logic [c3pf_pkg::Y_W-1:0]    out_y;
    logic                        frame_last;

    modport source (output valid, output filtered_value, output out_x, output out_y,
                    output frame_last, input ready);
    modport sink   (input valid, input filtered_value, input out_x, input out_y,
                    input frame_last, output ready);
endinterface

// ----- hw/rtl/c3pf_cfg_regs.sv -----
module c3pf_cfg_regs #(
    parameter int MAX_WIDTH = c3pf_pkg::DEF_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [c3pf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [c3pf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [c3pf_pkg::APB_DATA_W-1:0]   prdata,
    output c3pf_pkg::cfg_t                    cfg
);

    logic [c3pf_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [c3pf_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic [c3pf_pkg::KROW_W-1:0]       ktop_reg;
    logic [c3pf_pkg::KROW_W-1:0]       kmid_reg;
    logic [c3pf_pkg::KROW_W-1:0]       kbot_reg;
    logic [2:0]                        reg_sel;
    logic                              wr_en;

    assign reg_sel = paddr[c3pf_pkg::APB_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= c3pf_pkg::RST_IMAGE_WIDTH;
            height_reg <= c3pf_pkg::RST_IMAGE_HEIGHT;
            ktop_reg   <= c3pf_pkg::RST_KERNEL_TOP;
            kmid_reg   <= c3pf_pkg::RST_KERNEL_MID;
            kbot_reg   <= c3pf_pkg::RST_KERNEL_BOT;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                c3pf_pkg::REG_IMAGE_WIDTH:
                    width_reg <= pwdata[c3pf_pkg::WIDTH_REG_W-1:0];
                c3pf_pkg::REG_IMAGE_HEIGHT:
                    height_reg <= pwdata[c3pf_pkg::HEIGHT_REG_W-1:0];
                c3pf_pkg::REG_KERNEL_TOP:
                    ktop_reg <= pwdata[c3pf_pkg::KROW_W-1:0];
                c3pf_pkg::REG_KERNEL_MID:
                    kmid_reg <= pwdata[c3pf_pkg::KROW_W-1:0];
                c3pf_pkg::REG_KERNEL_BOT:
                    kbot_reg <= pwdata[c3pf_pkg::KROW_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            c3pf_pkg::REG_IMAGE_WIDTH:
                prdata = c3pf_pkg::APB_DATA_W'(width_reg);
            c3pf_pkg::REG_IMAGE_HEIGHT:
                prdata = c3pf_pkg::APB_DATA_W'(height_reg);
            c3pf_pkg::REG_KERNEL_TOP:
                prdata = c3pf_pkg::APB_DATA_W'(ktop_reg);
            c3pf_pkg::REG_KERNEL_MID:
                prdata = c3pf_pkg::APB_DATA_W'(kmid_reg);
            c3pf_pkg::REG_KERNEL_BOT:
                prdata = c3pf_pkg::APB_DATA_W'(kbot_reg);
            default:
                prdata = '0;
        endcase
    end

    // effective geometry, kept as last index
    always_comb
    begin
        if (width_reg < c3pf_pkg::WIDTH_REG_W'(3))
            cfg.width_m1 = c3pf_pkg::WIDTH_REG_W'(2);
        else if (32'(width_reg) > MAX_WIDTH)
            cfg.width_m1 = c3pf_pkg::WIDTH_REG_W'(MAX_WIDTH - 1);
        else
            cfg.width_m1 = width_reg - c3pf_pkg::WIDTH_REG_W'(1);

        if (height_reg < c3pf_pkg::HEIGHT_REG_W'(3))
            cfg.height_m1 = c3pf_pkg::HEIGHT_REG_W'(2);
        else
            cfg.height_m1 = height_reg - c3pf_pkg::HEIGHT_REG_W'(1);

        for (int k = 0; k < c3pf_pkg::KSIZE; k++)
        begin
            cfg.coef[k]                      = ktop_reg[c3pf_pkg::COEF_W*k +: c3pf_pkg::COEF_W];
            cfg.coef[c3pf_pkg::KSIZE + k]    = kmid_reg[c3pf_pkg::COEF_W*k +: c3pf_pkg::COEF_W];
            cfg.coef[2*c3pf_pkg::KSIZE + k]  = kbot_reg[c3pf_pkg::COEF_W*k +: c3pf_pkg::COEF_W];
        end
    end

endmodule

// ----- hw/rtl/c3pf_window.sv -----
module c3pf_window #(
    parameter int MAX_WIDTH = c3pf_pkg::DEF_MAX_WIDTH
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  c3pf_pkg::cfg_t                                 cfg,
    input  logic                                           in_valid,
    input  logic [c3pf_pkg::PIX_W-1:0]                     in_pixel,
    output logic                                           in_ready,
    output logic                                           nb_valid,
    input  logic                                           nb_ready,
    output logic [c3pf_pkg::TAPS-1:0][c3pf_pkg::PIX_W-1:0] nb_pix,
    output c3pf_pkg::tag_t                                 nb_tag
);

    localparam int CNT_W = $clog2(MAX_WIDTH);
    localparam int PW    = c3pf_pkg::PIX_W;
    localparam int K     = c3pf_pkg::KSIZE;

    // line store entry: upper byte two rows up, lower byte one row up
    logic [2*PW-1:0] mem [MAX_WIDTH];
    logic [2*PW-1:0] rd_reg;

    logic [CNT_W-1:0]              col_reg;
    logic [CNT_W-1:0]              col_next;
    logic [c3pf_pkg::Y_W-1:0]      row_reg;
    logic [c3pf_pkg::Y_W-1:0]      row_next;

    logic                          s1_valid_reg;
    logic                          s1_res_reg;
    logic [CNT_W-1:0]              s1_x_reg;
    logic [PW-1:0]                 s1_pix_reg;
    c3pf_pkg::tag_t                s1_tag_reg;

    logic [2*K-1:0][PW-1:0]        win_reg;
    logic [K-1:0][PW-1:0]          cur;

    logic                          accept;
    logic                          s1_adv;
    logic                          row_end;
    logic                          frame_end;
    logic                          has_res;
    c3pf_pkg::tag_t                tag_new;

    assign cur[0] = rd_reg[2*PW-1:PW];
    assign cur[1] = rd_reg[PW-1:0];
    assign cur[2] = s1_pix_reg;

    assign s1_adv   = s1_valid_reg && (!s1_res_reg || nb_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    assign row_end   = 32'(col_reg) >= 32'(cfg.width_m1);
    assign frame_end = row_reg >= cfg.height_m1;
    assign has_res   = (32'(col_reg) >= 32'd2) && (row_reg >= c3pf_pkg::Y_W'(2));

    always_comb
    begin
        tag_new.out_x      = c3pf_pkg::X_W'(col_reg - CNT_W'(1));
        tag_new.out_y      = row_reg - c3pf_pkg::Y_W'(1);
        tag_new.frame_last = row_end && frame_end;

        if (row_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : row_reg + c3pf_pkg::Y_W'(1);
        end
        else
        begin
            col_next = col_reg + CNT_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_res_reg   <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg    <= col_next;
                row_reg    <= row_next;
                s1_res_reg <= has_res;
            end
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_adv)
            begin
                for (int r = 0; r < K; r++)
                begin
                    win_reg[r]     <= win_reg[K + r];
                    win_reg[K + r] <= cur[r];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg     <= mem[col_reg];
            s1_x_reg   <= col_reg;
            s1_pix_reg <= in_pixel;
            s1_tag_reg <= tag_new;
        end
        if (s1_adv)
            mem[s1_x_reg] <= {rd_reg[PW-1:0], s1_pix_reg};
    end

    always_comb
    begin
        for (int r = 0; r < K; r++)
        begin
            nb_pix[K*r]     = win_reg[r];
            nb_pix[K*r + 1] = win_reg[K + r];
            nb_pix[K*r + 2] = cur[r];
        end
    end

    assign nb_valid = s1_valid_reg && s1_res_reg;
    assign nb_tag   = s1_tag_reg;

endmodule

// ----- hw/rtl/c3pf_mac.sv -----
module c3pf_mac (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  c3pf_pkg::cfg_t                                 cfg,
    input  logic                                           nb_valid,
    output logic                                           nb_ready,
    input  logic [c3pf_pkg::TAPS-1:0][c3pf_pkg::PIX_W-1:0] nb_pix,
    input  c3pf_pkg::tag_t                                 nb_tag,
    output logic                                           out_valid,
    input  logic                                           out_ready,
    output logic [c3pf_pkg::VAL_W-1:0]                     out_value,
    output c3pf_pkg::tag_t                                 out_tag
);

    localparam int K = c3pf_pkg::KSIZE;

    logic                                         p_valid_reg;
    logic signed [c3pf_pkg::PROD_W-1:0]           prod_reg [c3pf_pkg::TAPS];
    c3pf_pkg::tag_t                               p_tag_reg;

    logic                                         s_valid_reg;
    logic signed [c3pf_pkg::SUM_W-1:0]            sum_reg;
    logic signed [c3pf_pkg::SUM_W-1:0]            sum_next;
    logic signed [c3pf_pkg::SUM_W-1:0]            row_sum [K];
    c3pf_pkg::tag_t                               s_tag_reg;

    logic                                         o_valid_reg;
    logic [c3pf_pkg::VAL_W-1:0]                   o_value_reg;
    logic [c3pf_pkg::VAL_W-1:0]                   o_value_next;
    c3pf_pkg::tag_t                               o_tag_reg;

    logic                                         o_free;
    logic                                         s_free;
    logic                                         p_free;

    assign o_free   = !o_valid_reg || out_ready;
    assign s_free   = !s_valid_reg || o_free;
    assign p_free   = !p_valid_reg || s_free;
    assign nb_ready = p_free;

    always_comb
    begin
        for (int r = 0; r < K; r++)
        begin
            row_sum[r] = c3pf_pkg::SUM_W'(prod_reg[K*r])
                       + c3pf_pkg::SUM_W'(prod_reg[K*r + 1])
                       + c3pf_pkg::SUM_W'(prod_reg[K*r + 2]);
        end
        sum_next = row_sum[0] + row_sum[1] + row_sum[2];
    end

    // clamp to 0 .. 255.0
    always_comb
    begin
        if (sum_reg < 0)
            o_value_next = '0;
        else if (sum_reg > $signed(c3pf_pkg::SUM_W'(c3pf_pkg::VAL_MAX)))
            o_value_next = c3pf_pkg::VAL_MAX;
        else
            o_value_next = sum_reg[c3pf_pkg::VAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_free)
                p_valid_reg <= nb_valid;
            if (s_free)
                s_valid_reg <= p_valid_reg;
            if (o_free)
                o_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_free && nb_valid)
        begin
            for (int i = 0; i < c3pf_pkg::TAPS; i++)
                prod_reg[i] <= $signed({1'b0, nb_pix[i]}) * $signed(cfg.coef[i]);
            p_tag_reg <= nb_tag;
        end
        if (s_free && p_valid_reg)
        begin
            sum_reg   <= sum_next;
            s_tag_reg <= p_tag_reg;
        end
        if (o_free && s_valid_reg)
        begin
            o_value_reg <= o_value_next;
            o_tag_reg   <= s_tag_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_value = o_value_reg;
    assign out_tag   = o_tag_reg;

endmodule

// ----- hw/rtl/conv3x3_pixel_filter.sv -----
// channel   | dir | payload                                        | handshake
// pix_in    | in  | pixel[7:0]                                     | valid/ready
// res_out   | out | filtered_value[15:0] out_x[9:0] out_y[11:0]    | valid/ready
//           |     | frame_last                                     |
// apb       | in  | paddr[5:0] pwdata[63:0] prdata[63:0]           | psel/penable, pready=1
//
// one pixel per clock sustained while res_out.ready is held; a result is registered in the window stage,
// then in the mac product, sum and output registers. the line store is one 2-byte-wide ram, read on accept
// and written back when that pixel leaves the window stage. border pixels drop out after the first stage and
// leave bubbles in the mac pipe. reset clears counters, window and valids; line store content is not cleared
// a stalled result holds the pipe only once every mac stage is occupied
module conv3x3_pixel_filter #(
    parameter int MAX_WIDTH = c3pf_pkg::DEF_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [c3pf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [c3pf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [c3pf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    c3pf_pix_if.sink                          pix_in,
    c3pf_res_if.source                        res_out
);

    c3pf_pkg::cfg_t                                  cfg;
    logic                                            nb_valid;
    logic                                            nb_ready;
    logic [c3pf_pkg::TAPS-1:0][c3pf_pkg::PIX_W-1:0]  nb_pix;
    c3pf_pkg::tag_t                                  nb_tag;
    c3pf_pkg::tag_t                                  out_tag;
    logic                                            in_ready;
    logic                                            out_valid;
    logic [c3pf_pkg::VAL_W-1:0]                      out_value;

    assign pready = 1'b1;

    c3pf_cfg_regs #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    c3pf_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (pix_in.valid),
        .in_pixel (pix_in.pixel),
        .in_ready (in_ready),
        .nb_valid (nb_valid),
        .nb_ready (nb_ready),
        .nb_pix   (nb_pix),
        .nb_tag   (nb_tag)
    );

    c3pf_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .nb_valid  (nb_valid),
        .nb_ready  (nb_ready),
        .nb_pix    (nb_pix),
        .nb_tag    (nb_tag),
        .out_valid (out_valid),
        .out_ready (res_out.ready),
        .out_value (out_value),
        .out_tag   (out_tag)
    );

    assign pix_in.ready           = in_ready;
    assign res_out.valid          = out_valid;
    assign res_out.filtered_value = out_value;
    assign res_out.out_x          = out_tag.out_x;
    assign res_out.out_y          = out_tag.out_y;
    assign res_out.frame_last     = out_tag.frame_last;

`include "conv3x3_pixel_filter_assert.svh"

    `C3PF_ASSERT_NOW(a_clamp, out_valid, out_value <= c3pf_pkg::VAL_MAX, "result above 255.0")
    `C3PF_ASSERT_NOW(a_interior, out_valid, (out_tag.out_x != '0) && (out_tag.out_y != '0), "border position in result")
    `C3PF_ASSERT_NOW(a_stall_blocks, nb_valid && !nb_ready, !in_ready, "pixel taken over stalled window")
    `C3PF_ASSERT_NEXT(a_nb_hold, nb_valid && !nb_ready, nb_valid && $stable(nb_tag), "window word lost under stall")

endmodule
